// ----- rtl/core/ale_pkg.sv -----
// shared types and constants of the array linked list engine
package ale_pkg;

  localparam int DEF_SLOTS     = 10;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int IN_KEY_W      = 32;
  localparam int SLOT_IDX_W    = 4;

  typedef enum logic [1:0] {
    FUNC_INS_AFTER  = 2'd0,
    FUNC_INS_BEFORE = 2'd1,
    FUNC_DELETE     = 2'd2,
    FUNC_FIND       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PSCAN,
    ST_DSCAN,
    ST_INS_A,
    ST_INS_B,
    ST_DEL_A,
    ST_DEL_B,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    PH_ADDR,
    PH_LINK,
    PH_NEXT
  } phase_e;

  typedef struct packed {
    func_e                func;
    logic [IN_KEY_W-1:0]  search_key;
    logic [IN_KEY_W-1:0]  new_key;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [SLOT_IDX_W-1:0]  slot_index;
  } rsp_t;

endpackage

// ----- rtl/core/ale_ram.sv -----
// generic single write port ram with registered read
module ale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ale_seq.sv -----
// request sequencer: slot scans, list relinking and clearing pass
module ale_seq import ale_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH,
  localparam int LinkW = $clog2(SLOTS + 2),
  localparam int AddrW = $clog2(SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  req_t                 req_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  logic                 rsp_ready_i,
  output logic [AddrW-1:0]     mem_raddr_o,
  output logic [AddrW-1:0]     mem_waddr_o,
  output logic                 link_we_o,
  output logic [LinkW-1:0]     link_wdata_o,
  input  logic [LinkW-1:0]     link_rdata_i,
  output logic                 key_we_o,
  output logic [KEY_WIDTH-1:0] key_wdata_o,
  input  logic [KEY_WIDTH-1:0] key_rdata_i
);

  localparam int CntW = $clog2(SLOTS + 1);
  localparam logic [LinkW-1:0] LinkNull = {LinkW{1'b1}};
  localparam logic [LinkW-1:0] LastIdx  = LinkW'(SLOTS);
  localparam logic [LinkW-1:0] EndIdx   = LinkW'(SLOTS + 1);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [LinkW-1:0] idx_q, idx_d;
  logic [LinkW-1:0] tag_q, tag_d;
  logic tag_vld_q, tag_vld_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic hit_q, hit_d;
  logic [LinkW-1:0] hit_slot_q, hit_slot_d;
  logic [LinkW-1:0] hit_link_q, hit_link_d;
  logic fr_found_q, fr_found_d;
  logic [LinkW-1:0] fr_q, fr_d;
  logic pred_found_q, pred_found_d;
  logic [LinkW-1:0] pred_q, pred_d;
  logic [LinkW-1:0] nx_q, nx_d;
  func_e func_q, func_d;
  logic [KEY_WIDTH-1:0] skey_q, skey_d;
  logic [KEY_WIDTH-1:0] nkey_q, nkey_d;
  rsp_t rsp_q, rsp_d;

  logic scan_done;
  logic is_insert;
  logic list_full;
  logic list_empty;
  logic nx_used;

  assign scan_done  = (idx_q == EndIdx) && !tag_vld_q;
  assign is_insert  = req_i.func inside {FUNC_INS_AFTER, FUNC_INS_BEFORE};
  assign list_full  = cnt_q >= CntW'(SLOTS);
  assign list_empty = cnt_q == '0;
  assign nx_used    = (nx_q != '0) && (nx_q <= LastIdx) && (link_rdata_i != LinkNull);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (idx_q == LastIdx) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          if (is_insert) begin
            if (list_full) state_d = ST_RESP;
            else if (list_empty) state_d = ST_INS_A;
            else if (req_i.func == FUNC_INS_AFTER) state_d = ST_SCAN;
            else state_d = ST_PSCAN;
          end else if (list_empty) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (func_q)
            FUNC_DELETE:    state_d = hit_q ? ST_DSCAN : ST_RESP;
            FUNC_INS_AFTER: state_d = (hit_q && fr_found_q) ? ST_INS_A : ST_RESP;
            default:        state_d = ST_RESP;
          endcase
        end
      end
      ST_DSCAN: begin
        if (scan_done) state_d = pred_found_q ? ST_DEL_A : ST_RESP;
      end
      ST_PSCAN: begin
        if (ph_q == PH_ADDR && idx_q == EndIdx) begin
          state_d = (hit_q && fr_found_q) ? ST_INS_A : ST_RESP;
        end
      end
      ST_INS_A: state_d = ST_INS_B;
      ST_INS_B: state_d = ST_RESP;
      ST_DEL_A: state_d = ST_DEL_B;
      ST_DEL_B: state_d = ST_RESP;
      ST_RESP: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    ph_d         = ph_q;
    idx_d        = idx_q;
    tag_d        = tag_q;
    tag_vld_d    = 1'b0;
    cnt_d        = cnt_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    hit_link_d   = hit_link_q;
    fr_found_d   = fr_found_q;
    fr_d         = fr_q;
    pred_found_d = pred_found_q;
    pred_d       = pred_q;
    nx_d         = nx_q;
    func_d       = func_q;
    skey_d       = skey_q;
    nkey_d       = nkey_q;
    rsp_d        = rsp_q;
    mem_raddr_o  = idx_q[AddrW-1:0];
    mem_waddr_o  = idx_q[AddrW-1:0];
    link_we_o    = 1'b0;
    link_wdata_o = LinkNull;
    key_we_o     = 1'b0;
    key_wdata_o  = nkey_q;
    case (state_q)
      ST_CLEAR: begin
        link_we_o    = 1'b1;
        link_wdata_o = (idx_q == '0) ? '0 : LinkNull;
        idx_d        = idx_q + 1'b1;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          func_d       = req_i.func;
          skey_d       = KEY_WIDTH'(req_i.search_key);
          nkey_d       = KEY_WIDTH'(req_i.new_key);
          hit_d        = 1'b0;
          fr_found_d   = 1'b0;
          pred_found_d = 1'b0;
          ph_d         = PH_ADDR;
          rsp_d        = '{status: STAT_OK, slot_index: '0};
          idx_d        = (req_i.func == FUNC_INS_BEFORE) ? '0 : LinkW'(1);
          if (is_insert) begin
            if (list_full) begin
              rsp_d.status = STAT_FULL;
            end else if (list_empty) begin
              fr_d       = LinkW'(1);
              hit_slot_d = '0;
              hit_link_d = '0;
            end
          end else if (list_empty) begin
            rsp_d.status = STAT_EMPTY;
          end
        end
      end
      ST_SCAN, ST_DSCAN: begin
        if (idx_q <= LastIdx) begin
          idx_d     = idx_q + 1'b1;
          tag_d     = idx_q;
          tag_vld_d = 1'b1;
        end
        if (tag_vld_q) begin
          if (state_q == ST_SCAN) begin
            if (link_rdata_i == LinkNull && !fr_found_q) begin
              fr_found_d = 1'b1;
              fr_d       = tag_q;
            end
            if (link_rdata_i != LinkNull && key_rdata_i == skey_q && !hit_q) begin
              hit_d      = 1'b1;
              hit_slot_d = tag_q;
              hit_link_d = link_rdata_i;
            end
          end else if (!pred_found_q && link_rdata_i == hit_slot_q) begin
            pred_found_d = 1'b1;
            pred_d       = tag_q;
          end
        end
        if (scan_done) begin
          if (state_q == ST_DSCAN) begin
            if (!pred_found_q) rsp_d.status = STAT_MISS;
            else rsp_d.slot_index = SLOT_IDX_W'(hit_slot_q);
          end else if (!hit_q) begin
            rsp_d.status = STAT_MISS;
          end else if (func_q == FUNC_FIND) begin
            rsp_d.slot_index = SLOT_IDX_W'(hit_slot_q);
          end else if (func_q == FUNC_DELETE) begin
            idx_d = '0;
          end else if (!fr_found_q) begin
            rsp_d.status = STAT_FULL;
          end
        end
      end
      ST_PSCAN: begin
        case (ph_q)
          PH_ADDR: begin
            if (idx_q <= LastIdx) begin
              ph_d = PH_LINK;
            end else if (!hit_q) begin
              rsp_d.status = STAT_MISS;
            end else if (!fr_found_q) begin
              rsp_d.status = STAT_FULL;
            end
          end
          PH_LINK: begin
            if (idx_q != '0 && link_rdata_i == LinkNull) begin
              if (!fr_found_q) begin
                fr_found_d = 1'b1;
                fr_d       = idx_q;
              end
              idx_d = idx_q + 1'b1;
              ph_d  = PH_ADDR;
            end else begin
              nx_d        = link_rdata_i;
              mem_raddr_o = link_rdata_i[AddrW-1:0];
              ph_d        = PH_NEXT;
            end
          end
          PH_NEXT: begin
            if (nx_used && key_rdata_i == skey_q && !hit_q) begin
              hit_d      = 1'b1;
              hit_slot_d = idx_q;
              hit_link_d = nx_q;
            end
            idx_d = idx_q + 1'b1;
            ph_d  = PH_ADDR;
          end
          default: ph_d = PH_ADDR;
        endcase
      end
      ST_INS_A: begin
        mem_waddr_o  = fr_q[AddrW-1:0];
        key_we_o     = 1'b1;
        link_we_o    = 1'b1;
        link_wdata_o = hit_link_q;
      end
      ST_INS_B: begin
        mem_waddr_o      = hit_slot_q[AddrW-1:0];
        link_we_o        = 1'b1;
        link_wdata_o     = fr_q;
        cnt_d            = cnt_q + 1'b1;
        rsp_d.slot_index = SLOT_IDX_W'(fr_q);
      end
      ST_DEL_A: begin
        mem_waddr_o  = pred_q[AddrW-1:0];
        link_we_o    = 1'b1;
        link_wdata_o = hit_link_q;
      end
      ST_DEL_B: begin
        mem_waddr_o  = hit_slot_q[AddrW-1:0];
        link_we_o    = 1'b1;
        link_wdata_o = LinkNull;
        cnt_d        = cnt_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      ph_q         <= PH_ADDR;
      idx_q        <= '0;
      tag_vld_q    <= 1'b0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      fr_found_q   <= 1'b0;
      pred_found_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ph_q         <= ph_d;
      idx_q        <= idx_d;
      tag_vld_q    <= tag_vld_d;
      cnt_q        <= cnt_d;
      hit_q        <= hit_d;
      fr_found_q   <= fr_found_d;
      pred_found_q <= pred_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    hit_slot_q <= hit_slot_d;
    hit_link_q <= hit_link_d;
    fr_q       <= fr_d;
    pred_q     <= pred_d;
    nx_q       <= nx_d;
    func_q     <= func_d;
    skey_q     <= skey_d;
    nkey_q     <= nkey_d;
    rsp_q      <= rsp_d;
  end

endmodule

// ----- rtl/core/array_linked_list_engine.sv -----
// top level of the array linked list engine
//
// A circular singly linked list of up to SLOTS keys lives in two simple dual
// port rams (keys and links) of SLOTS+1 entries; entry 0 is the list header.
// Requests arrive on req_valid_i/req_ready_o with req_i (func, search_key,
// new_key); each gives exactly one response on rsp_valid_o/rsp_ready_i with
// rsp_o (status, slot_index), in request order.
// One request is in work at a time; its cost is set by the walk over the
// ram through its single read port, one entry per cycle, or in an address,
// a link and a key phase per entry where a link must be followed (insert
// before); delete walks the ram twice, and full, empty or first insert
// need no walk.
// The response sits in an output register, so the next request is taken
// while a response is still held by a stalled receiver.
// After reset a clearing pass sets the header to point at itself and
// marks every data slot free; req_ready_o stays low meanwhile.
module array_linked_list_engine import ale_pkg::*; #(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int LinkW = $clog2(SLOTS + 2);
  localparam int AddrW = $clog2(SLOTS + 1);

  logic [AddrW-1:0]     mem_raddr;
  logic [AddrW-1:0]     mem_waddr;
  logic                 link_we;
  logic [LinkW-1:0]     link_wdata;
  logic [LinkW-1:0]     link_rdata;
  logic                 key_we;
  logic [KEY_WIDTH-1:0] key_wdata;
  logic [KEY_WIDTH-1:0] key_rdata;

  logic seq_rsp_valid;
  logic seq_rsp_ready;
  rsp_t seq_rsp;

  logic out_valid_q, out_valid_d;
  rsp_t out_q;

  ale_seq #(
    .SLOTS     (SLOTS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_i),
    .req_i        (req_i),
    .req_ready_o  (req_ready_o),
    .rsp_valid_o  (seq_rsp_valid),
    .rsp_o        (seq_rsp),
    .rsp_ready_i  (seq_rsp_ready),
    .mem_raddr_o  (mem_raddr),
    .mem_waddr_o  (mem_waddr),
    .link_we_o    (link_we),
    .link_wdata_o (link_wdata),
    .link_rdata_i (link_rdata),
    .key_we_o     (key_we),
    .key_wdata_o  (key_wdata),
    .key_rdata_i  (key_rdata)
  );

  ale_ram #(
    .WIDTH (LinkW),
    .DEPTH (SLOTS + 1)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (mem_waddr),
    .wdata_i (link_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (link_rdata)
  );

  ale_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (SLOTS + 1)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (mem_waddr),
    .wdata_i (key_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (key_rdata)
  );

  // output register
  assign seq_rsp_ready = !out_valid_q || rsp_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_rsp_valid && seq_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_rsp_valid && seq_rsp_ready) begin
      out_q <= seq_rsp;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
